FILE: sv/gfi_pkg.sv
// Shared types, constants and face tables of the grid face incidence block.
package gfi_pkg;

   localparam int MAX_DIM   = 256;
   localparam int DIM_RESET = 16;
   localparam int FID_W     = 26;
   localparam int NID_W     = 25;
   localparam int DIMIN_W   = 9;
   localparam int IDX_W     = 2;
   localparam int NODE_W    = 24;
   localparam int EDGE_W    = 26;
   localparam int QDEPTH    = 2;

   // ceil(2^28 / 3): floor(x * RECIP3 / 2^28) equals x / 3 for every 26-bit x.
   localparam logic [26:0] RECIP3 = 27'd89478486;
   localparam int RECIP_SHIFT = 28;

   typedef enum logic [IDX_W-1:0] {
      REG_DIM_X = 2'd0,
      REG_DIM_Y = 2'd1,
      REG_DIM_Z = 2'd2
   } reg_index_type;

   // Corner offsets per face type and position, bits are {x, y, z}.
   localparam logic [2:0] NODE_OFF [0:2][0:3] = '{
      '{3'b000, 3'b010, 3'b011, 3'b001},
      '{3'b000, 3'b001, 3'b101, 3'b100},
      '{3'b000, 3'b100, 3'b110, 3'b010}};

   // Edge base node offsets per face type and position, bits are {x, y, z}.
   localparam logic [2:0] EDGE_OFF [0:2][0:3] = '{
      '{3'b000, 3'b010, 3'b001, 3'b000},
      '{3'b000, 3'b001, 3'b100, 3'b000},
      '{3'b000, 3'b100, 3'b010, 3'b000}};

   localparam logic [1:0] EDGE_KIND [0:2][0:3] = '{
      '{2'd1, 2'd2, 2'd1, 2'd2},
      '{2'd2, 2'd0, 2'd2, 2'd0},
      '{2'd0, 2'd1, 2'd0, 2'd1}};

   typedef struct packed {
      logic [FID_W-1:0] face_id;
      logic [1:0]       face_type;
      logic             corners_only;
   } qe_type;

   typedef struct packed {
      logic              valid_res;
      logic [1:0]        face_type;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [NODE_W-1:0] node_c;
      logic [NODE_W-1:0] node_d;
      logic [EDGE_W-1:0] edge_a;
      logic [EDGE_W-1:0] edge_b;
      logic [EDGE_W-1:0] edge_c;
      logic [EDGE_W-1:0] edge_d;
      logic [NODE_W-1:0] cell_front;
      logic [NODE_W-1:0] cell_back;
   } rs_type;

endpackage

FILE: sv/gfi_req_if.sv
// Request channel interface carrying face queries.
interface gfi_req_if;
   logic                      valid;
   logic                      ready;
   logic [gfi_pkg::FID_W-1:0] face_id;
   logic                      corners_only;

   modport source (output valid, output face_id, output corners_only, input ready);
   modport sink (input valid, input face_id, input corners_only, output ready);
endinterface

FILE: sv/gfi_rsp_if.sv
// Response channel interface carrying face incidence results.
interface gfi_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       valid_res;
   logic [1:0]                 face_type;
   logic [gfi_pkg::NODE_W-1:0] node_a;
   logic [gfi_pkg::NODE_W-1:0] node_b;
   logic [gfi_pkg::NODE_W-1:0] node_c;
   logic [gfi_pkg::NODE_W-1:0] node_d;
   logic [gfi_pkg::EDGE_W-1:0] edge_a;
   logic [gfi_pkg::EDGE_W-1:0] edge_b;
   logic [gfi_pkg::EDGE_W-1:0] edge_c;
   logic [gfi_pkg::EDGE_W-1:0] edge_d;
   logic [gfi_pkg::NODE_W-1:0] cell_front;
   logic [gfi_pkg::NODE_W-1:0] cell_back;

   modport source (output valid, output valid_res, output face_type, output node_a,
                   output node_b, output node_c, output node_d, output edge_a,
                   output edge_b, output edge_c, output edge_d, output cell_front,
                   output cell_back, input ready);
   modport sink (input valid, input valid_res, input face_type, input node_a,
                 input node_b, input node_c, input node_d, input edge_a,
                 input edge_b, input edge_c, input edge_d, input cell_front,
                 input cell_back, output ready);
endinterface

FILE: sv/gfi_csr_if.sv
// Register write channel interface.
interface gfi_csr_if;
   logic                        valid;
   logic                        ready;
   logic [gfi_pkg::IDX_W-1:0]   index;
   logic [gfi_pkg::DIMIN_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/gfi_front.sv
// Front end: accepts face queries and classifies the face type.
module gfi_front (
   gfi_req_if.sink          req,
   output logic             push_valid,
   input  logic             push_ready,
   output gfi_pkg::qe_type  push_data
);

   logic [27:0] fid_ext;
   logic [6:0]  hex_sum;
   logic [3:0]  quad_sum;
   logic [2:0]  fold;
   logic [1:0]  ftype;

   // Base 16 and base 4 both leave remainder one modulo three, so digit sums keep it.
   always_comb begin
      fid_ext = {2'b00, req.face_id};
      hex_sum = '0;
      for (int d = 0; d < 7; d++) begin
         hex_sum = hex_sum + {3'b000, fid_ext[d*4 +: 4]};
      end
      quad_sum = {2'b00, hex_sum[1:0]} + {2'b00, hex_sum[3:2]} + {2'b00, hex_sum[5:4]}
                 + {3'b000, hex_sum[6]};
      fold = {1'b0, quad_sum[1:0]} + {1'b0, quad_sum[3:2]};
      if (fold >= 3'd3) begin
         ftype = 2'(fold - 3'd3);
      end else begin
         ftype = fold[1:0];
      end
   end

   assign push_valid             = req.valid;
   assign req.ready              = push_ready;
   assign push_data.face_id      = req.face_id;
   assign push_data.face_type    = ftype;
   assign push_data.corners_only = req.corners_only;

endmodule

FILE: sv/gfi_queue.sv
// Short queue between the front end and the compute pipeline.
module gfi_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  gfi_pkg::qe_type push_data,
   output logic            pop_valid,
   input  logic            pop_ready,
   output gfi_pkg::qe_type pop_data
);

   localparam int AW = (gfi_pkg::QDEPTH > 1) ? $clog2(gfi_pkg::QDEPTH) : 1;

   gfi_pkg::qe_type mem_ff [gfi_pkg::QDEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != (AW+1)'(gfi_pkg::QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(gfi_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(gfi_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/gfi_back.sv
// Compute pipeline: coordinate split, validity check and incidence ids.
module gfi_back #(
   parameter  int MAX_DIM = gfi_pkg::MAX_DIM,
   localparam int DW      = $clog2(MAX_DIM + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  gfi_pkg::qe_type     pop_data,
   input  logic [2:0][DW-1:0]  dim,
   gfi_rsp_if.source           rsp
);

   localparam int QW = $clog2(MAX_DIM);
   localparam int SW = 2 * DW;
   localparam int NW = gfi_pkg::NID_W;
   localparam int TW = NW + SW;
   localparam int LW = (3 * DW > gfi_pkg::NODE_W) ? 3 * DW : gfi_pkg::NODE_W;
   localparam int EW = LW + 2;
   localparam int NS = 2 * QW;
   localparam logic [12:0] K_HI = gfi_pkg::RECIP3[26:14];
   localparam logic [13:0] K_LO = gfi_pkg::RECIP3[13:0];

   typedef struct packed {
      logic       vld;
      logic [1:0] t;
      logic       no;
      logic [38:0] hi;
      logic [39:0] lo;
   } m1_type;

   typedef struct packed {
      logic          vld;
      logic [1:0]    t;
      logic          no;
      logic          bad;
      logic [NW-1:0] rem;
      logic [QW-1:0] cz;
      logic [QW-1:0] cy;
   } dv_type;

   typedef struct packed {
      logic          vld;
      logic [1:0]    t;
      logic          no;
      logic          ok;
      logic [DW-1:0] i;
      logic [DW-1:0] i1;
      logic [DW-1:0] ib;
      logic [DW-1:0] j;
      logic [DW-1:0] j1;
      logic [DW-1:0] jb;
      logic [DW-1:0] k;
      logic [DW-1:0] k1;
      logic [DW-1:0] kb;
   } p1_type;

   typedef struct packed {
      logic            vld;
      logic [1:0]      t;
      logic            no;
      logic            ok;
      logic [DW-1:0]   i;
      logic [DW-1:0]   i1;
      logic [DW-1:0]   ib;
      logic [SW-1:0]   xj0;
      logic [SW-1:0]   xj1;
      logic [SW-1:0]   xjb;
      logic [3*DW-1:0] sk0;
      logic [3*DW-1:0] sk1;
      logic [3*DW-1:0] skb;
   } p2_type;

   typedef struct packed {
      logic                vld;
      logic [1:0]          t;
      logic                no;
      logic                ok;
      logic [3:0][LW-1:0]  nd;
      logic [3:0][LW-1:0]  ed;
      logic [3:0][1:0]     et;
      logic [LW-1:0]       cf;
      logic [LW-1:0]       cb;
   } p3_type;

   logic            en;
   logic [SW-1:0]   s_ff, s_in;
   logic [3*DW-1:0] sdz_ff, sdz_in;
   m1_type          m1_ff, m1_in;
   dv_type          dv_ff [0:NS];
   dv_type          dv0_in;
   p1_type          p1_ff, p1_in;
   p2_type          p2_ff, p2_in;
   p3_type          p3_ff, p3_in;
   gfi_pkg::rs_type out_ff, out_in;
   logic            out_vld_ff;
   logic [53:0]     prod;

   function automatic logic [DW-1:0] step_up(input logic [DW-1:0] c, input logic [DW-1:0] d);
      logic [DW:0] c1;
      c1 = {1'b0, c} + 1'b1;
      return (c1 >= {1'b0, d}) ? '0 : c1[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] step_dn(input logic [DW-1:0] c, input logic [DW-1:0] d);
      return (c == '0) ? d - 1'b1 : c - 1'b1;
   endfunction

   assign en        = !out_vld_ff || rsp.ready;
   assign pop_ready = en;

   // Plane size and grid size follow the dimension registers.
   assign s_in   = SW'(dim[0]) * SW'(dim[1]);
   assign sdz_in = (3*DW)'(s_ff) * (3*DW)'(dim[2]);

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      sdz_ff <= sdz_in;
   end

   // Node index is the face id divided by three, as two partial products.
   always_comb begin
      m1_in.vld = pop_valid;
      m1_in.t   = pop_data.face_type;
      m1_in.no  = pop_data.corners_only;
      m1_in.hi  = 39'(pop_data.face_id) * 39'(K_HI);
      m1_in.lo  = 40'(pop_data.face_id) * 40'(K_LO);
   end

   always_comb begin
      prod       = (54'(m1_ff.hi) << 14) + 54'(m1_ff.lo);
      dv0_in.vld = m1_ff.vld;
      dv0_in.t   = m1_ff.t;
      dv0_in.no  = m1_ff.no;
      dv0_in.rem = prod[gfi_pkg::RECIP_SHIFT +: NW];
      dv0_in.bad = (TW'(prod[gfi_pkg::RECIP_SHIFT +: NW]) >= TW'(sdz_ff));
      dv0_in.cz  = '0;
      dv0_in.cy  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff.vld    <= 1'b0;
         dv_ff[0].vld <= 1'b0;
      end else if (en) begin
         m1_ff    <= m1_in;
         dv_ff[0] <= dv0_in;
      end
   end

   // Restoring division, one quotient bit per stage: first by the plane size, then by dim x.
   for (genvar g = 0; g < NS; g++) begin : g_div
      logic [TW-1:0] trial;
      logic          ge;
      dv_type        nxt;

      assign ge = (TW'(dv_ff[g].rem) >= trial);

      if (g < QW) begin : g_z
         assign trial = TW'(s_ff) << (QW - 1 - g);
         always_comb begin
            nxt = dv_ff[g];
            if (ge) begin
               nxt.rem            = dv_ff[g].rem - trial[NW-1:0];
               nxt.cz[QW - 1 - g] = 1'b1;
            end
         end
      end else begin : g_y
         assign trial = TW'(dim[0]) << (NS - 1 - g);
         always_comb begin
            nxt = dv_ff[g];
            if (ge) begin
               nxt.rem            = dv_ff[g].rem - trial[NW-1:0];
               nxt.cy[NS - 1 - g] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g+1].vld <= 1'b0;
         end else if (en) begin
            dv_ff[g+1] <= nxt;
         end
      end
   end

   // Validity under non-periodic rules and the stepped coordinates.
   always_comb begin
      logic [DW-1:0] ci, cj, ck;
      logic [2:0]    far;
      logic          inr;
      ci = dv_ff[NS].rem[DW-1:0];
      cj = DW'(dv_ff[NS].cy);
      ck = DW'(dv_ff[NS].cz);
      inr = (ci < dim[0]) && (cj < dim[1]) && (ck < dim[2]);
      far[0] = (ci == dim[0] - 1'b1);
      far[1] = (cj == dim[1] - 1'b1);
      far[2] = (ck == dim[2] - 1'b1);
      p1_in.vld = dv_ff[NS].vld;
      p1_in.t   = dv_ff[NS].t;
      p1_in.no  = dv_ff[NS].no;
      p1_in.ok  = !dv_ff[NS].bad && inr &&
                  ((far == 3'b000) || (far == (3'b001 << dv_ff[NS].t)));
      p1_in.i   = ci;
      p1_in.j   = cj;
      p1_in.k   = ck;
      p1_in.i1  = step_up(ci, dim[0]);
      p1_in.j1  = step_up(cj, dim[1]);
      p1_in.k1  = step_up(ck, dim[2]);
      p1_in.ib  = (dv_ff[NS].t == 2'd0) ? step_dn(ci, dim[0]) : ci;
      p1_in.jb  = (dv_ff[NS].t == 2'd1) ? step_dn(cj, dim[1]) : cj;
      p1_in.kb  = (dv_ff[NS].t == 2'd2) ? step_dn(ck, dim[2]) : ck;
   end

   always_comb begin
      p2_in.vld = p1_ff.vld;
      p2_in.t   = p1_ff.t;
      p2_in.no  = p1_ff.no;
      p2_in.ok  = p1_ff.ok;
      p2_in.i   = p1_ff.i;
      p2_in.i1  = p1_ff.i1;
      p2_in.ib  = p1_ff.ib;
      p2_in.xj0 = SW'(dim[0]) * SW'(p1_ff.j);
      p2_in.xj1 = SW'(dim[0]) * SW'(p1_ff.j1);
      p2_in.xjb = SW'(dim[0]) * SW'(p1_ff.jb);
      p2_in.sk0 = (3*DW)'(s_ff) * (3*DW)'(p1_ff.k);
      p2_in.sk1 = (3*DW)'(s_ff) * (3*DW)'(p1_ff.k1);
      p2_in.skb = (3*DW)'(s_ff) * (3*DW)'(p1_ff.kb);
   end

   always_comb begin
      logic [2:0] noff, eoff;
      p3_in.vld = p2_ff.vld;
      p3_in.t   = p2_ff.t;
      p3_in.no  = p2_ff.no;
      p3_in.ok  = p2_ff.ok;
      for (int p = 0; p < 4; p++) begin
         noff = gfi_pkg::NODE_OFF[p2_ff.t][p];
         eoff = gfi_pkg::EDGE_OFF[p2_ff.t][p];
         p3_in.nd[p] = LW'(noff[2] ? p2_ff.i1 : p2_ff.i) + LW'(noff[1] ? p2_ff.xj1 : p2_ff.xj0)
                       + LW'(noff[0] ? p2_ff.sk1 : p2_ff.sk0);
         p3_in.ed[p] = LW'(eoff[2] ? p2_ff.i1 : p2_ff.i) + LW'(eoff[1] ? p2_ff.xj1 : p2_ff.xj0)
                       + LW'(eoff[0] ? p2_ff.sk1 : p2_ff.sk0);
         p3_in.et[p] = gfi_pkg::EDGE_KIND[p2_ff.t][p];
      end
      p3_in.cf = LW'(p2_ff.i) + LW'(p2_ff.xj0) + LW'(p2_ff.sk0);
      p3_in.cb = LW'(p2_ff.ib) + LW'(p2_ff.xjb) + LW'(p2_ff.skb);
   end

   always_comb begin
      logic [3:0][EW-1:0] eid;
      for (int p = 0; p < 4; p++) begin
         eid[p] = (EW'(p3_ff.ed[p]) << 1) + EW'(p3_ff.ed[p]) + EW'(p3_ff.et[p]);
      end
      out_in = '0;
      if (p3_ff.ok) begin
         out_in.valid_res = 1'b1;
         out_in.face_type = p3_ff.t;
         out_in.node_a    = p3_ff.nd[0][gfi_pkg::NODE_W-1:0];
         out_in.node_b    = p3_ff.nd[1][gfi_pkg::NODE_W-1:0];
         out_in.node_c    = p3_ff.nd[2][gfi_pkg::NODE_W-1:0];
         out_in.node_d    = p3_ff.nd[3][gfi_pkg::NODE_W-1:0];
         if (!p3_ff.no) begin
            out_in.edge_a     = eid[0][gfi_pkg::EDGE_W-1:0];
            out_in.edge_b     = eid[1][gfi_pkg::EDGE_W-1:0];
            out_in.edge_c     = eid[2][gfi_pkg::EDGE_W-1:0];
            out_in.edge_d     = eid[3][gfi_pkg::EDGE_W-1:0];
            out_in.cell_front = p3_ff.cf[gfi_pkg::NODE_W-1:0];
            out_in.cell_back  = p3_ff.cb[gfi_pkg::NODE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.vld  <= 1'b0;
         p2_ff.vld  <= 1'b0;
         p3_ff.vld  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         p1_ff      <= p1_in;
         p2_ff      <= p2_in;
         p3_ff      <= p3_in;
         out_ff     <= out_in;
         out_vld_ff <= p3_ff.vld;
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.valid_res  = out_ff.valid_res;
   assign rsp.face_type  = out_ff.face_type;
   assign rsp.node_a     = out_ff.node_a;
   assign rsp.node_b     = out_ff.node_b;
   assign rsp.node_c     = out_ff.node_c;
   assign rsp.node_d     = out_ff.node_d;
   assign rsp.edge_a     = out_ff.edge_a;
   assign rsp.edge_b     = out_ff.edge_b;
   assign rsp.edge_c     = out_ff.edge_c;
   assign rsp.edge_d     = out_ff.edge_d;
   assign rsp.cell_front = out_ff.cell_front;
   assign rsp.cell_back  = out_ff.cell_back;

endmodule

FILE: sv/grid_face_incidence_ids.sv
// Top level of the grid face incidence block with its dimension registers.
//
//   channel   dir   transfer when        payload
//   req_ch    in    valid && ready       face_id, corners_only
//   rsp_ch    out   valid && ready       valid_res, face_type, node_a..d, edge_a..d, cells
//   csr_ch    in    valid && ready       index, data (ready is always high)
//
// One query is accepted per cycle while the queue has room; the response passes through
// the queue, the partial products, the bit-per-stage coordinate division and the id stages.
// Reset clears the pipeline and the queue and sets every dimension to 16.
// A stalled response holds the whole pipeline; the queue holds up to two requests.
module grid_face_incidence_ids #(
   parameter int MAX_DIM = gfi_pkg::MAX_DIM
) (
   input logic       clock,
   input logic       reset,
   gfi_req_if.sink   req_ch,
   gfi_rsp_if.source rsp_ch,
   gfi_csr_if.sink   csr_ch
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int RST_DIM = (gfi_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : gfi_pkg::DIM_RESET;

   logic [2:0][DW-1:0] dim_ff, dim_in;
   logic [DW-1:0]      wr_val;
   logic               push_valid, push_ready, pop_valid, pop_ready;
   gfi_pkg::qe_type    push_data, pop_data;

   assign csr_ch.ready = 1'b1;

   // Values above the largest dimension saturate.
   assign wr_val = (32'(csr_ch.data) > MAX_DIM) ? DW'(MAX_DIM) : DW'(csr_ch.data);

   always_comb begin
      dim_in = dim_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            gfi_pkg::REG_DIM_X: dim_in[0] = wr_val;
            gfi_pkg::REG_DIM_Y: dim_in[1] = wr_val;
            gfi_pkg::REG_DIM_Z: dim_in[2] = wr_val;
            default: dim_in = dim_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= {3{DW'(RST_DIM)}};
      end else begin
         dim_ff <= dim_in;
      end
   end

   gfi_front u_front (
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   gfi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   gfi_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .dim       (dim_ff),
      .rsp       (rsp_ch)
   );

endmodule

FILE: sv/gfi_checker.sv
// Port-level checks on the response channel, bound to the top level.
module gfi_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       valid_res,
   input logic [1:0]                 face_type,
   input logic [gfi_pkg::NODE_W-1:0] node_a,
   input logic [gfi_pkg::NODE_W-1:0] node_d,
   input logic [gfi_pkg::EDGE_W-1:0] edge_a,
   input logic [gfi_pkg::NODE_W-1:0] cell_front,
   input logic [gfi_pkg::NODE_W-1:0] cell_back
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(node_a) && $stable(valid_res))
      else $error("response changed while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !valid_res |-> face_type == 2'd0 && node_a == '0 && node_d == '0 &&
                                  edge_a == '0 && cell_front == '0 && cell_back == '0)
      else $error("invalid face with nonzero fields");

   a_type_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && valid_res |-> face_type != 2'd3)
      else $error("face type out of range");

   a_front_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && valid_res && cell_front != '0 |-> cell_front == node_a)
      else $error("front cell differs from first corner node");

endmodule

bind grid_face_incidence_ids gfi_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .valid_res  (rsp_ch.valid_res),
   .face_type  (rsp_ch.face_type),
   .node_a     (rsp_ch.node_a),
   .node_d     (rsp_ch.node_d),
   .edge_a     (rsp_ch.edge_a),
   .cell_front (rsp_ch.cell_front),
   .cell_back  (rsp_ch.cell_back)
);

FILE: bench/gfi_checker.sv
// Checker that predicts face incidence results and compares every response transfer.
`timescale 1ns / 100ps
module gfi_scoreboard (
   input  logic  clock,
   input  logic  reset,
   gfi_req_if    req_ch,
   gfi_rsp_if    rsp_ch,
   gfi_csr_if    csr_ch,
   output int    fail_count,
   output int    pending
);

   localparam int CORNER [0:2][0:3][0:2] = '{
      '{'{0,0,0}, '{0,1,0}, '{0,1,1}, '{0,0,1}},
      '{'{0,0,0}, '{0,0,1}, '{1,0,1}, '{1,0,0}},
      '{'{0,0,0}, '{1,0,0}, '{1,1,0}, '{0,1,0}}};
   localparam int SIDE [0:2][0:3][0:3] = '{
      '{'{0,0,0,1}, '{0,1,0,2}, '{0,0,1,1}, '{0,0,0,2}},
      '{'{0,0,0,2}, '{0,0,1,0}, '{1,0,0,2}, '{0,0,0,0}},
      '{'{0,0,0,0}, '{1,0,0,1}, '{0,1,0,0}, '{0,0,0,1}}};

   longint dims [0:2];
   gfi_pkg::rs_type incidence_q [$];

   function automatic longint wrap_up(longint c, longint d, int inc);
      if (inc == 0) return c;
      return (c + 1 >= d) ? 0 : c + 1;
   endfunction

   function automatic longint lin_id(longint i, longint j, longint k);
      return i + dims[0] * (j + dims[1] * k);
   endfunction

   function automatic gfi_pkg::rs_type face_incidence(logic [gfi_pkg::FID_W-1:0] fid,
                                                      logic corners_only);
      gfi_pkg::rs_type r;
      longint nid, s, id;
      longint c [0:2];
      longint b [0:2];
      longint n [0:2];
      int t, far_count, far_axis;
      r = '0;
      far_count = 0;
      far_axis = 0;
      if (dims[0] == 0 || dims[1] == 0 || dims[2] == 0) return r;
      t = int'(fid % 3);
      nid = longint'(fid) / 3;
      s = dims[0] * dims[1];
      c[2] = nid / s;
      c[1] = (nid - c[2] * s) / dims[0];
      c[0] = nid - c[2] * s - c[1] * dims[0];
      for (int a = 0; a < 3; a++) begin
         if (c[a] >= dims[a]) return r;
         if (c[a] == dims[a] - 1) begin
            far_count++;
            far_axis = a;
         end
      end
      if (far_count > 1) return r;
      if (far_count == 1 && far_axis != t) return r;
      r.valid_res = 1'b1;
      r.face_type = t[1:0];
      for (int p = 0; p < 4; p++) begin
         for (int a = 0; a < 3; a++) n[a] = wrap_up(c[a], dims[a], CORNER[t][p][a]);
         id = lin_id(n[0], n[1], n[2]);
         case (p)
            0: r.node_a = id[gfi_pkg::NODE_W-1:0];
            1: r.node_b = id[gfi_pkg::NODE_W-1:0];
            2: r.node_c = id[gfi_pkg::NODE_W-1:0];
            default: r.node_d = id[gfi_pkg::NODE_W-1:0];
         endcase
      end
      if (corners_only) return r;
      for (int p = 0; p < 4; p++) begin
         for (int a = 0; a < 3; a++) n[a] = wrap_up(c[a], dims[a], SIDE[t][p][a]);
         id = lin_id(n[0], n[1], n[2]) * 3 + SIDE[t][p][3];
         case (p)
            0: r.edge_a = id[gfi_pkg::EDGE_W-1:0];
            1: r.edge_b = id[gfi_pkg::EDGE_W-1:0];
            2: r.edge_c = id[gfi_pkg::EDGE_W-1:0];
            default: r.edge_d = id[gfi_pkg::EDGE_W-1:0];
         endcase
      end
      id = lin_id(c[0], c[1], c[2]);
      r.cell_front = id[gfi_pkg::NODE_W-1:0];
      for (int a = 0; a < 3; a++) b[a] = c[a];
      b[t] = (c[t] == 0) ? dims[t] - 1 : c[t] - 1;
      id = lin_id(b[0], b[1], b[2]);
      r.cell_back = id[gfi_pkg::NODE_W-1:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      gfi_pkg::rs_type want;
      longint v;
      if (reset) begin
         for (int a = 0; a < 3; a++) dims[a] = longint'(gfi_pkg::DIM_RESET);
         incidence_q.delete();
         fail_count = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            v = longint'(csr_ch.data);
            if (v > gfi_pkg::MAX_DIM) v = gfi_pkg::MAX_DIM;
            case (gfi_pkg::reg_index_type'(csr_ch.index))
               gfi_pkg::REG_DIM_X: dims[0] = v;
               gfi_pkg::REG_DIM_Y: dims[1] = v;
               gfi_pkg::REG_DIM_Z: dims[2] = v;
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (incidence_q.size() == 0) begin
               $error("response transfer with no query outstanding");
               fail_count++;
            end else begin
               want = incidence_q.pop_front();
               check_field("valid_res", 32'(want.valid_res), 32'(rsp_ch.valid_res));
               check_field("face_type", 32'(want.face_type), 32'(rsp_ch.face_type));
               check_field("node_a", 32'(want.node_a), 32'(rsp_ch.node_a));
               check_field("node_b", 32'(want.node_b), 32'(rsp_ch.node_b));
               check_field("node_c", 32'(want.node_c), 32'(rsp_ch.node_c));
               check_field("node_d", 32'(want.node_d), 32'(rsp_ch.node_d));
               check_field("edge_a", 32'(want.edge_a), 32'(rsp_ch.edge_a));
               check_field("edge_b", 32'(want.edge_b), 32'(rsp_ch.edge_b));
               check_field("edge_c", 32'(want.edge_c), 32'(rsp_ch.edge_c));
               check_field("edge_d", 32'(want.edge_d), 32'(rsp_ch.edge_d));
               check_field("cell_front", 32'(want.cell_front), 32'(rsp_ch.cell_front));
               check_field("cell_back", 32'(want.cell_back), 32'(rsp_ch.cell_back));
            end
         end
         if (req_ch.valid && req_ch.ready)
            incidence_q = {incidence_q,
                           face_incidence(req_ch.face_id, req_ch.corners_only)};
      end
      pending = incidence_q.size();
   end
endmodule

FILE: bench/testbench.sv
// Top of the bench: clock, reset, query and register stimulus, and the verdict.
`timescale 1ns / 100ps
module testbench;

   localparam int FW = gfi_pkg::FID_W;
   localparam int LATENCY = 2 * $clog2(gfi_pkg::MAX_DIM) + 9;
   localparam int IDLE_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   idle_cycles = 0;
   bit   no_idle = 0;
   int   rsp_wait = 0;

   gfi_req_if req_ch ();
   gfi_rsp_if rsp_ch ();
   gfi_csr_if csr_ch ();

   grid_face_incidence_ids u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch));

   gfi_scoreboard u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch),
      .fail_count(fail_count), .pending(pending));

   always #4 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.face_id = '0;
      req_ch.corners_only = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (no_idle) begin
            rsp_wait <= 0;
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_wait <= $urandom_range(0, 9);
            rsp_ch.ready <= 1'b0;
         end
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_query(logic [FW-1:0] fid, logic only);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.face_id <= fid;
      req_ch.corners_only <= only;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_dim(gfi_pkg::reg_index_type idx, int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value[gfi_pkg::DIMIN_W-1:0];
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int sat_dim(int v);
      return (v > gfi_pkg::MAX_DIM) ? gfi_pkg::MAX_DIM : v;
   endfunction

   function automatic logic [FW-1:0] make_face(int dx, int dy, int dz, int i, int j,
                                               int k, int t);
      longint v;
      v = (longint'(i) + longint'(dx) * (j + longint'(dy) * k)) * 3 + t;
      return v[FW-1:0];
   endfunction

   function automatic int pick_coord(int d);
      if (d <= 0) return $urandom_range(0, 3);
      case ($urandom_range(0, 9))
         0, 1, 2: return d - 1;
         3: return 0;
         4: return d;
         default: return $urandom_range(0, d - 1);
      endcase
   endfunction

   task automatic random_phase(int dx, int dy, int dz, int count);
      int i, j, k, t;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         if ($urandom_range(0, 4) == 0) begin
            send_query(FW'($urandom()), 1'($urandom_range(0, 1)));
         end else begin
            i = pick_coord(dx);
            j = pick_coord(dy);
            k = pick_coord(dz);
            t = $urandom_range(0, 2);
            send_query(make_face(dx, dy, dz, i, j, k, t), 1'($urandom_range(0, 1)));
         end
      end
      drain();
   endtask

   initial begin
      int dx, dy, dz;
      int raw [0:2];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int t = 0; t < 3; t++) begin
         send_query(make_face(16, 16, 16, 0, 0, 0, t), 1'b0);
         send_query(make_face(16, 16, 16, 15, 14, 14, t), 1'b0);
         send_query(make_face(16, 16, 16, 14, 15, 14, t), 1'b1);
         send_query(make_face(16, 16, 16, 14, 14, 15, t), 1'b0);
         send_query(make_face(16, 16, 16, 15, 15, 3, t), 1'b0);
         send_query(make_face(16, 16, 16, 5, 6, 7, t), 1'b1);
      end
      send_query({FW{1'b1}}, 1'b0);
      send_query({FW{1'b1}}, 1'b1);
      send_query(make_face(16, 16, 16, 0, 0, 16, 0), 1'b0);
      send_query(make_face(16, 16, 16, 15, 15, 15, 2), 1'b0);
      drain();

      random_phase(16, 16, 16, 180);
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: raw = '{1, 1, 1};
            1: raw = '{256, 256, 256};
            2: raw = '{0, 5, 5};
            3: raw = '{511, 2, 300};
            4: raw = '{2, 2, 2};
            5: raw = '{7, 0, 3};
            default: raw = '{$urandom_range(1, 20), $urandom_range(1, 20),
                             $urandom_range(1, 20)};
         endcase
         write_dim(gfi_pkg::REG_DIM_X, raw[0]);
         write_dim(gfi_pkg::REG_DIM_Y, raw[1]);
         write_dim(gfi_pkg::REG_DIM_Z, raw[2]);
         dx = sat_dim(raw[0]);
         dy = sat_dim(raw[1]);
         dz = sat_dim(raw[2]);
         no_idle = (ph % 3 == 1);
         random_phase(dx, dy, dz, 200);
      end
      no_idle = 0;

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

FILE: grid_face_incidence_ids.f
sv/gfi_pkg.sv
sv/gfi_req_if.sv
sv/gfi_rsp_if.sv
sv/gfi_csr_if.sv
sv/gfi_front.sv
sv/gfi_queue.sv
sv/gfi_back.sv
sv/grid_face_incidence_ids.sv
sv/gfi_checker.sv
bench/gfi_checker.sv
bench/testbench.sv
